[rtl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Types and constants shared by the floppy-control port block.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned CNT_W   = 25;            // spindle count, config regs
  localparam int unsigned SUM_W   = CNT_W + 1;     // count + tick cycles
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEP_W  = $clog2(SUM_W);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] ROTATION_RESET    = CNT_W'(1600000);
  localparam logic [CNT_W-1:0] INDEX_PULSE_RESET = CNT_W'(32256);
  localparam logic [7:0]       PORT_C_RESET      = 8'h02;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_PULSE = CFG_IDX_W'(1);

  // port C bit positions
  localparam int unsigned PC_MOTOR_N = 1;
  localparam int unsigned PC_TC      = 2;
  localparam int unsigned PC_FDC_RST = 3;
  localparam int unsigned PC_IPL_N   = 6;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_WR_PORT_C = 3'd1,
    OP_WR_CTRL   = 3'd2,
    OP_RD_PORT_A = 3'd3,
    OP_RD_PORT_C = 3'd4,
    OP_RD_CTRL   = 3'd5,
    OP_INSERT    = 3'd6,
    OP_EJECT     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_IDX
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] rotation_clocks;
    logic [CNT_W-1:0] index_pulse_clocks;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W:0] diff;
    logic           ge;
  } alu_rsp_t;

endpackage

[rtl/pfc_intf.sv]
// ----------------------------------------------------------------------------
// pfc_intf
// Request and response channels of the floppy-control port block.
// ----------------------------------------------------------------------------
interface pfc_req_if;
  import pfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic [7:0]          data;
  logic [TICK_W-1:0]   tick_cycles;
  logic                disk_present;
  logic                fdc_interrupt;

  modport source (output valid, op, data, tick_cycles, disk_present, fdc_interrupt,
                  input ready);
  modport sink   (input valid, op, data, tick_cycles, disk_present, fdc_interrupt,
                  output ready);
endinterface

interface pfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       motor_running;
  logic       index_level;
  logic       fdc_reset_pulse;
  logic       tc_write;
  logic       tc_level;
  logic       ipl_rom_enabled;

  modport source (output valid, read_data, motor_running, index_level, fdc_reset_pulse,
                  tc_write, tc_level, ipl_rom_enabled, input ready);
  modport sink   (input valid, read_data, motor_running, index_level, fdc_reset_pulse,
                  tc_write, tc_level, ipl_rom_enabled, output ready);
endinterface

[rtl/pfc_alu.sv]
// ----------------------------------------------------------------------------
// pfc_alu
// Shared compare/subtract unit: wrap test, division steps, index compare.
// ----------------------------------------------------------------------------
module pfc_alu import pfc_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    rsp_o.diff = {1'b0, req_i.a} - {2'b00, req_i.b};
    rsp_o.ge   = ~rsp_o.diff[SUM_W];
  end

endmodule

[rtl/pfc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// Rotation length and index pulse width registers.
// ----------------------------------------------------------------------------
module pfc_cfg_regs import pfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION:    cfg_d.rotation_clocks    = cfg_wdata_i;
        CFG_INDEX_PULSE: cfg_d.index_pulse_clocks = cfg_wdata_i;
        default:         cfg_d = cfg_q;   // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_clocks    <= ROTATION_RESET;
      cfg_q.index_pulse_clocks <= INDEX_PULSE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ppi_floppy_control_with_index_pulse.sv]
// ----------------------------------------------------------------------------
// ppi_floppy_control_with_index_pulse
// Floppy-control side of a parallel port: port C latch with bit set/reset,
// spindle motor, controller reset and terminal count, and index pulse timing.
// ----------------------------------------------------------------------------
// Port accesses, disk events and idle ticks: response registered in the cycle after
// the request is accepted. A tick with the motor running passes the wrap check and
// the index compare. When the new count reaches a nonzero rotation length, the tick also
// takes 26 restoring remainder steps through the shared compare/subtract unit in between.
// No new request is taken until the response is registered. Asynchronous active-low
// reset sets the port latches and config registers to their power-up values.
module ppi_floppy_control_with_index_pulse import pfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  pfc_req_if.sink              req_i,
  pfc_rsp_if.source            rsp_o
);

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  pfc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  pfc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  state_e state_q, state_d;

  logic [7:0]        port_c_q, port_c_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic              index_q, index_d;
  logic              spin_q, spin_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              disk_q, disk_d;

  logic       rsp_valid_q, rsp_valid_d;
  logic [7:0] rd_q, rd_d;
  logic       rst_pulse_q, rst_pulse_d;
  logic       tcw_q, tcw_d;
  logic       tcl_q, tcl_d;

  logic       accept;
  logic       tick_math;
  logic       rot_zero;
  logic [7:0] pc_new;
  logic [7:0] bit_mask;
  logic [CNT_W-1:0] div_shift;

  op_e op;
  assign op = op_e'(req_i.op);

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign tick_math   = (op == OP_TICK) && (req_i.tick_cycles != '0) && spin_q;
  assign rot_zero    = (cfg.rotation_clocks == '0);
  assign bit_mask    = 8'(1) << req_i.data[3:1];
  assign div_shift   = alu_req.a[CNT_W-1:0];

  // shared unit operand select
  always_comb begin
    case (state_q)
      ST_CHK: begin
        alu_req.a = sum_q;
        alu_req.b = cfg.rotation_clocks;
      end
      ST_DIV: begin
        alu_req.a = {rem_q, sum_q[step_q]};
        alu_req.b = cfg.rotation_clocks;
      end
      ST_IDX: begin
        alu_req.a = {1'b0, count_q};
        alu_req.b = cfg.index_pulse_clocks;
      end
      default: begin
        alu_req.a = '0;
        alu_req.b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && tick_math) state_d = ST_CHK;
      ST_CHK:  state_d = (!rot_zero && alu_rsp.ge) ? ST_DIV : ST_IDX;
      ST_DIV:  if (step_q == '0) state_d = ST_IDX;
      ST_IDX:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and response
  always_comb begin
    port_c_d    = port_c_q;
    ctrl_d      = ctrl_q;
    index_d     = index_q;
    spin_d      = spin_q;
    count_d     = count_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    step_d      = step_q;
    disk_d      = disk_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rd_d        = rd_q;
    rst_pulse_d = rst_pulse_q;
    tcw_d       = tcw_q;
    tcl_d       = tcl_q;
    pc_new      = port_c_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d        = '0;
          rst_pulse_d = 1'b0;
          tcw_d       = 1'b0;
          tcl_d       = 1'b0;
          rsp_valid_d = !tick_math;
          case (op)
            OP_TICK: begin
              if (req_i.tick_cycles != '0) begin
                if (spin_q) begin
                  sum_d  = {1'b0, count_q} + SUM_W'(req_i.tick_cycles);
                  disk_d = req_i.disk_present;
                end else begin
                  index_d = 1'b0;
                end
              end
            end
            OP_WR_PORT_C, OP_WR_CTRL: begin
              if (op == OP_WR_CTRL) begin
                ctrl_d = req_i.data;
                pc_new = req_i.data[0] ? (port_c_q | bit_mask) : (port_c_q & ~bit_mask);
                tcw_d  = !req_i.data[7] && (req_i.data[3:1] == 3'(PC_TC));
                tcl_d  = !req_i.data[7] && (req_i.data[3:1] == 3'(PC_TC)) && req_i.data[0];
              end else begin
                pc_new = req_i.data;
              end
              // bit 7 set on a control word only latches the control byte
              if (op == OP_WR_PORT_C || !req_i.data[7]) begin
                port_c_d    = pc_new;
                spin_d      = !pc_new[PC_MOTOR_N] && req_i.disk_present;
                rst_pulse_d = !port_c_q[PC_FDC_RST] && pc_new[PC_FDC_RST];
              end
            end
            OP_RD_PORT_A: rd_d = {5'b0, index_q, 1'b0, req_i.fdc_interrupt};
            OP_RD_PORT_C: rd_d = port_c_q;
            OP_RD_CTRL:   rd_d = ctrl_q;
            OP_INSERT:    count_d = '0;
            OP_EJECT:     spin_d = 1'b0;
            default:      spin_d = spin_q;
          endcase
        end
      end
      ST_CHK: begin
        if (rot_zero || !alu_rsp.ge) begin
          count_d = sum_q[CNT_W-1:0];
        end else begin
          rem_d  = '0;
          step_d = STEP_W'(SUM_W - 1);
        end
      end
      ST_DIV: begin
        rem_d  = alu_rsp.ge ? alu_rsp.diff[CNT_W-1:0] : div_shift;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) count_d = rem_d;
      end
      ST_IDX: begin
        index_d     = disk_q && !alu_rsp.ge;
        rsp_valid_d = 1'b1;
      end
      default: begin
        rsp_valid_d = rsp_valid_q && !rsp_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      port_c_q    <= PORT_C_RESET;
      ctrl_q      <= '0;
      index_q     <= 1'b1;
      spin_q      <= 1'b0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      port_c_q    <= port_c_d;
      ctrl_q      <= ctrl_d;
      index_q     <= index_d;
      spin_q      <= spin_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    rem_q       <= rem_d;
    step_q      <= step_d;
    disk_q      <= disk_d;
    rd_q        <= rd_d;
    rst_pulse_q <= rst_pulse_d;
    tcw_q       <= tcw_d;
    tcl_q       <= tcl_d;
  end

  // status fields follow the latches, which do not change while a response is held valid
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.read_data       = rd_q;
  assign rsp_o.motor_running   = spin_q;
  assign rsp_o.index_level     = index_q;
  assign rsp_o.fdc_reset_pulse = rst_pulse_q;
  assign rsp_o.tc_write        = tcw_q;
  assign rsp_o.tc_level        = tcl_q;
  assign rsp_o.ipl_rom_enabled = !port_c_q[PC_IPL_N];

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == ST_IDLE))
    else $error("request taken while busy");

  a_rem_below_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cfg.rotation_clocks))
    else $error("partial remainder out of range");

  a_count_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDX && !rot_zero) |-> (count_q < cfg.rotation_clocks))
    else $error("spindle count not reduced");

  a_tick_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDX) |=> rsp_valid_q)
    else $error("tick finished without response");

  a_no_tc_on_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !req_i.ready)
    else $error("ready during division");

endmodule

[tb/ppi_floppy_control_with_index_pulse_test.sv]
// ----------------------------------------------------------------------------
// ppi_floppy_control_with_index_pulse_test
// Self-checking bench for the floppy-control port block. A scoreboard class
// tracks port latches, spindle motor and spindle count, predicts every
// response and checks it field by field. Directed port accesses come first,
// then a long spin-up across the count wrap, then random phases under
// several rotation and index pulse settings with random idling on both sides.
// ----------------------------------------------------------------------------
module ppi_floppy_control_with_index_pulse_test;
  import pfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_GUARD  = 4;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PA_INDEX    = 2;
  localparam logic [7:0]  PORT_A_RESET = 8'h04;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [TICK_W-1:0] cycles;
    logic              disk;
    logic              irq;
  } port_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       motor_running;
    logic       index_level;
    logic       fdc_reset_pulse;
    logic       tc_write;
    logic       tc_level;
    logic       ipl_rom_enabled;
  } port_result_t;

  class floppy_port_scoreboard;
    logic [CNT_W-1:0] rotation;
    logic [CNT_W-1:0] pulse_width;
    logic [7:0]       port_a;
    logic [7:0]       port_c;
    logic [7:0]       ctrl;
    logic             spin_on;
    logic [CNT_W-1:0] spin_count;
    port_result_t     pending_results[$];
    int unsigned      errors;

    function new();
      rotation    = ROTATION_RESET;
      pulse_width = INDEX_PULSE_RESET;
      port_a      = PORT_A_RESET;
      port_c      = PORT_C_RESET;
      ctrl        = '0;
      spin_on     = 1'b0;
      spin_count  = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      if (idx == CFG_ROTATION) begin
        rotation = value;
      end else if (idx == CFG_INDEX_PULSE) begin
        pulse_width = value;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_request(port_req_t r);
      port_result_t exp_rsp;
      logic [7:0]   new_c;
      logic [31:0]  total;
      logic         writes_c;
      logic [2:0]   pos;
      exp_rsp  = '0;
      writes_c = 1'b0;
      new_c    = port_c;
      case (r.op)
        OP_TICK: begin
          if (r.cycles != 0) begin
            if (spin_on) begin
              total = 32'(spin_count) + 32'(r.cycles);
              if (rotation != 0) begin
                total = total % 32'(rotation);
              end
              spin_count = total[CNT_W-1:0];
              port_a[PA_INDEX] = r.disk && (spin_count < pulse_width);
            end else begin
              port_a[PA_INDEX] = 1'b0;
            end
          end
        end
        OP_WR_PORT_C: begin
          writes_c = 1'b1;
          new_c    = r.data;
        end
        OP_WR_CTRL: begin
          ctrl = r.data;
          // bit 7 clear: set/reset of a single port C bit
          if (!r.data[7]) begin
            pos        = r.data[3:1];
            new_c[pos] = r.data[0];
            writes_c   = 1'b1;
            if (pos == 3'(PC_TC)) begin
              exp_rsp.tc_write = 1'b1;
              exp_rsp.tc_level = r.data[0];
            end
          end
        end
        OP_RD_PORT_A: exp_rsp.read_data = port_a | {7'b0, r.irq};
        OP_RD_PORT_C: exp_rsp.read_data = port_c;
        OP_RD_CTRL:   exp_rsp.read_data = ctrl;
        OP_INSERT:    spin_count = '0;
        OP_EJECT:     spin_on = 1'b0;
        default: begin
        end
      endcase
      if (writes_c) begin
        exp_rsp.fdc_reset_pulse = !port_c[PC_FDC_RST] && new_c[PC_FDC_RST];
        port_c  = new_c;
        spin_on = !new_c[PC_MOTOR_N] && r.disk;
      end
      exp_rsp.motor_running   = spin_on;
      exp_rsp.index_level     = port_a[PA_INDEX];
      exp_rsp.ipl_rom_enabled = !port_c[PC_IPL_N];
      pending_results.push_back(exp_rsp);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(port_result_t got);
      port_result_t want;
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("motor_running", 8'(want.motor_running), 8'(got.motor_running));
      compare_field("index_level", 8'(want.index_level), 8'(got.index_level));
      compare_field("fdc_reset_pulse", 8'(want.fdc_reset_pulse), 8'(got.fdc_reset_pulse));
      compare_field("tc_write", 8'(want.tc_write), 8'(got.tc_write));
      compare_field("tc_level", 8'(want.tc_level), 8'(got.tc_level));
      compare_field("ipl_rom_enabled", 8'(want.ipl_rom_enabled), 8'(got.ipl_rom_enabled));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CNT_W-1:0]     cfg_wdata_i;

  pfc_req_if req_if ();
  pfc_rsp_if rsp_if ();

  ppi_floppy_control_with_index_pulse u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  floppy_port_scoreboard port_model;
  port_result_t          seen;
  int unsigned           cycle_count = 0;
  bit                    gap_free = 1'b0;
  bit                    hold_request = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen.read_data       = rsp_if.read_data;
      seen.motor_running   = rsp_if.motor_running;
      seen.index_level     = rsp_if.index_level;
      seen.fdc_reset_pulse = rsp_if.fdc_reset_pulse;
      seen.tc_write        = rsp_if.tc_write;
      seen.tc_level        = rsp_if.tc_level;
      seen.ipl_rom_enabled = rsp_if.ipl_rom_enabled;
      port_model.check_response(seen);
    end
  end

  // response side: random stalls, steady stretches, and one long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned steady_left;
    int unsigned stall_left;
    int unsigned pick;
    hold_left   = 0;
    steady_left = 0;
    stall_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady_left != 0) begin
        steady_left--;
        rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          steady_left = $urandom_range(20, 80);
          rsp_if.ready <= 1'b1;
        end else if (pick < 30) begin
          stall_left = (pick < 27) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (gap_free) begin
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic port_req_t make_req(op_e op, logic [7:0] data,
                                         logic [TICK_W-1:0] cycles, logic disk,
                                         logic irq);
    port_req_t r;
    r.op     = op;
    r.data   = data;
    r.cycles = cycles;
    r.disk   = disk;
    r.irq    = irq;
    return r;
  endfunction

  function automatic port_req_t random_request();
    port_req_t   r;
    int unsigned pick;
    int unsigned size_pick;
    pick     = $urandom_range(99);
    r.data   = 8'($urandom);
    r.cycles = TICK_W'($urandom);
    r.disk   = ($urandom_range(9) != 0);
    r.irq    = 1'($urandom);
    if (pick < 40) begin
      r.op      = OP_TICK;
      size_pick = $urandom_range(9);
      if (size_pick == 0) begin
        r.cycles = '0;
      end else if (size_pick < 5) begin
        r.cycles = TICK_W'($urandom_range(1, 300));
      end
    end else if (pick < 55) begin
      r.op = OP_WR_PORT_C;
      // mostly keep the motor enabled so ticks have something to do
      if ($urandom_range(9) < 7) begin
        r.data[PC_MOTOR_N] = 1'b0;
      end
    end else if (pick < 70) begin
      r.op = OP_WR_CTRL;
      if ($urandom_range(3) != 0) begin
        r.data[7] = 1'b0;
      end
    end else if (pick < 88) begin
      r.op = op_e'(3'($urandom_range(OP_RD_PORT_A, OP_RD_CTRL)));
    end else if (pick < 94) begin
      r.op = OP_INSERT;
    end else begin
      r.op = OP_EJECT;
    end
    return r;
  endfunction

  task automatic send_request(port_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= r.op;
    req_if.data          <= r.data;
    req_if.tick_cycles   <= r.cycles;
    req_if.disk_present  <= r.disk;
    req_if.fdc_interrupt <= r.irq;
    do @(posedge clk_i); while (!req_if.ready);
    port_model.note_request(r);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (port_model.pending() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    port_model.set_register(idx, value);
  endtask

  task automatic reconfigure(logic [CNT_W-1:0] rot, logic [CNT_W-1:0] pulse);
    wait_idle();
    program_register(CFG_ROTATION, rot);
    program_register(CFG_INDEX_PULSE, pulse);
    // unmapped index, must be ignored
    program_register($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CNT_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  task automatic big_ticks(int unsigned count);
    repeat (count) begin
      send_request(make_req(OP_TICK, 8'($urandom), TICK_W'($urandom_range(64000, 65535)),
                            $urandom_range(7) != 0, 1'($urandom)));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] rot;
    port_model = new();
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_wdata_i          <= '0;
    req_if.valid         <= 1'b0;
    req_if.op            <= OP_TICK;
    req_if.data          <= '0;
    req_if.tick_cycles   <= '0;
    req_if.disk_present  <= 1'b0;
    req_if.fdc_interrupt <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, tick corners, set/reset on each special bit
    send_request(make_req(OP_RD_PORT_A, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_RD_PORT_C, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_RD_CTRL, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 8'h00, 16'd100, 1'b1, 1'b0));
    send_request(make_req(OP_RD_PORT_A, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_req(OP_WR_PORT_C, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 8'h00, 16'hFFFF, 1'b1, 1'b0));
    send_request(make_req(OP_INSERT, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 8'h00, 16'd1, 1'b1, 1'b1));
    send_request(make_req(OP_RD_PORT_A, 8'h00, 16'd0, 1'b1, 1'b1));
    send_request(make_req(OP_TICK, 8'h00, 16'd500, 1'b0, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h07, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h05, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h04, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h0D, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h0E, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h03, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'h80, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_CTRL, 8'hFF, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_RD_CTRL, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_PORT_C, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_PORT_C, 8'hFF, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_WR_PORT_C, 8'h00, 16'd0, 1'b0, 1'b0));
    send_request(make_req(OP_WR_PORT_C, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_EJECT, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 8'h00, 16'd300, 1'b1, 1'b0));

    // spin the count up close to 2^25 without wrapping, then drop the wrap
    reconfigure(CNT_MAX, CNT_W'(25'h0FFFFFF));
    send_request(make_req(OP_WR_PORT_C, 8'h00, 16'd0, 1'b1, 1'b0));
    send_request(make_req(OP_INSERT, 8'h00, 16'd0, 1'b1, 1'b0));
    big_ticks(505);
    reconfigure('0, CNT_W'($urandom_range(1000, 2000000)));
    big_ticks(25);
    // count now sits above the new rotation length
    reconfigure(CNT_W'(5000), CNT_W'(2500));
    big_ticks(3);
    run_random(40);

    // random phases; first one with the sender never idling
    gap_free = 1'b1;
    reconfigure(CNT_W'(1), CNT_W'(1));
    run_random(140);
    gap_free = 1'b0;
    reconfigure(CNT_W'(40000), '0);
    run_random(140);
    reconfigure('0, CNT_MAX);
    run_random(140);
    rot = CNT_W'($urandom_range(2, 70000));
    reconfigure(rot, CNT_W'($urandom_range(0, rot)));
    run_random(140);
    // long receiver hold while requests keep coming
    gap_free = 1'b1;
    reconfigure(ROTATION_RESET, INDEX_PULSE_RESET);
    hold_request = 1'b1;
    run_random(140);
    gap_free = 1'b0;
    rot = CNT_W'($urandom_range(100, 2000));
    reconfigure(rot, rot >> 2);
    run_random(140);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (port_model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
